// ===== src/blca_pkg.sv =====
// Shared sizes, codes and request types of the tree ancestor engine.
package blca_pkg;

  // Tree and table sizes
  localparam int MAX_NODES = 1024;
  localparam int LEVELS    = 11;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int DEPTH_W   = 10;
  localparam int STEP_W    = 10;
  localparam int FIELD_W   = 10;
  localparam int JT_DEPTH  = LEVELS * MAX_NODES;
  localparam int JT_AW     = LVL_W + NODE_W;

  // Step bits at table level LEVELS and above are ignored
  localparam logic [STEP_W-1:0] STEP_MASK =
    (LEVELS >= STEP_W) ? {STEP_W{1'b1}} : STEP_W'((1 << LEVELS) - 1);

  // Request kinds carried in s_tuser
  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_BUILD = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_JUMP  = 2'd3
  } action_t;

  // Result kinds carried in m_tuser
  localparam logic KIND_LCA  = 1'b0;
  localparam logic KIND_JUMP = 1'b1;

  // One input request
  typedef struct packed {
    action_t              action;
    logic [FIELD_W-1:0]   node;
    logic [FIELD_W-1:0]   other_node;
    logic [DEPTH_W-1:0]   node_depth;
    logic [STEP_W-1:0]    steps;
  } item_t;

  // Jump table port request
  typedef struct packed {
    logic              we;
    logic [JT_AW-1:0]  waddr;
    logic [NODE_W-1:0] wdata;
    logic [JT_AW-1:0]  raddr;
  } jt_req_t;

  // Depth store port request
  typedef struct packed {
    logic               we;
    logic [NODE_W-1:0]  waddr;
    logic [DEPTH_W-1:0] wdata;
    logic [NODE_W-1:0]  raddr;
  } dp_req_t;

endpackage

// ===== src/blca_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port.
module blca_ram #(
  parameter int DATA_W = 10,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/blca_engine.sv =====
// Sequencer that walks the jump table for writes, builds, jumps and lca queries.
module blca_engine
  import blca_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  item_t              in_item,
  input  logic [CNT_W-1:0]   node_count,
  output jt_req_t            jt,
  input  logic [NODE_W-1:0]  jt_rdata,
  output dp_req_t            dp,
  input  logic [DEPTH_W-1:0] dp_rdata,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [NODE_W-1:0]  out_node,
  output logic               out_kind
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_B_ADDR,
    S_B_HOP,
    S_B_STORE,
    S_Q_DB,
    S_Q_CMP,
    S_C_STEP,
    S_C_WAIT,
    S_D_RA,
    S_D_RB,
    S_D_CMP,
    S_F_WAIT,
    S_DONE
  } state_t;

  state_t             state;
  logic [NODE_W-1:0]  a_node;
  logic [NODE_W-1:0]  b_node;
  logic [NODE_W-1:0]  ca;
  logic [NODE_W-1:0]  res;
  logic [NODE_W-1:0]  j;
  logic [LVL_W-1:0]   lvl;
  logic [STEP_W-1:0]  rem;
  logic [DEPTH_W-1:0] da;
  logic               kind;

  logic [NODE_W-1:0]  in_a;
  logic [NODE_W-1:0]  in_b;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   j_inc;
  logic               last_j;
  logic [LVL_W-1:0]   lvl_dn;
  logic               differ;
  logic [NODE_W-1:0]  a_next;
  logic [NODE_W-1:0]  b_next;

  // Reduce indices to the table and saturate the build count
  assign in_a   = in_item.node[NODE_W-1:0];
  assign in_b   = in_item.other_node[NODE_W-1:0];
  assign cnt    = (node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count;
  assign j_inc  = {1'b0, j} + CNT_W'(1);
  assign last_j = (j_inc == cnt);
  assign lvl_dn = lvl - LVL_W'(1);

  // Descent compare: move both nodes while their ancestors differ
  assign differ = (ca != jt_rdata);
  assign a_next = differ ? ca : a_node;
  assign b_next = differ ? jt_rdata : b_node;

  assign in_ready = (state == S_IDLE);

  // Memory requests
  always_comb begin
    jt       = '0;
    jt.raddr = {lvl, a_node};
    dp       = '0;
    dp.raddr = a_node;
    case (state)
      S_IDLE: begin
        dp.raddr = in_a;
        if (in_valid && in_item.action == ACT_WRITE) begin
          jt.we    = 1'b1;
          jt.waddr = {LVL_W'(0), in_a};
          jt.wdata = in_b;
          dp.we    = 1'b1;
          dp.waddr = in_a;
          dp.wdata = in_item.node_depth;
        end
      end
      S_Q_DB:   dp.raddr = b_node;
      S_B_ADDR: jt.raddr = {lvl_dn, j};
      S_B_HOP:  jt.raddr = {lvl_dn, jt_rdata};
      S_B_STORE: begin
        jt.we    = 1'b1;
        jt.waddr = {lvl, j};
        jt.wdata = jt_rdata;
        jt.raddr = {lvl_dn, j_inc[NODE_W-1:0]};
      end
      S_D_RB:   jt.raddr = {lvl, b_node};
      // After the bottom level, fetch the parent of the final node
      S_D_CMP:  jt.raddr = {(lvl == '0) ? lvl : lvl_dn, a_next};
      default:  jt.raddr = {lvl, a_node};
    endcase
  end

  // Sequencer state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            a_node <= in_a;
            b_node <= in_b;
            lvl    <= (in_item.action == ACT_BUILD) ? LVL_W'(1) : LVL_W'(0);
            rem    <= in_item.steps & STEP_MASK;
            case (in_item.action)
              ACT_BUILD: begin
                j   <= '0;
                if (cnt != '0) begin
                  state <= S_B_ADDR;
                end
              end
              ACT_QUERY: begin
                kind  <= KIND_LCA;
                state <= S_Q_DB;
              end
              ACT_JUMP: begin
                kind  <= KIND_JUMP;
                state <= S_C_STEP;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        // Build: two chained reads of the level below, then store
        S_B_ADDR: state <= S_B_HOP;
        S_B_HOP:  state <= S_B_STORE;
        S_B_STORE: begin
          if (!last_j) begin
            j     <= j_inc[NODE_W-1:0];
            state <= S_B_HOP;
          end else if (lvl == LVL_W'(LEVELS - 1)) begin
            state <= S_IDLE;
          end else begin
            lvl   <= lvl + LVL_W'(1);
            j     <= '0;
            state <= S_B_ADDR;
          end
        end
        // Query: fetch both depths, lift the deeper node
        S_Q_DB: begin
          da    <= dp_rdata;
          state <= S_Q_CMP;
        end
        S_Q_CMP: begin
          if (da < dp_rdata) begin
            a_node <= b_node;
            b_node <= a_node;
            rem    <= STEP_W'(dp_rdata - da) & STEP_MASK;
          end else begin
            rem    <= STEP_W'(da - dp_rdata) & STEP_MASK;
          end
          lvl   <= LVL_W'(0);
          state <= S_C_STEP;
        end
        // Climb: one table read per set step bit
        S_C_STEP: begin
          if (rem == '0) begin
            if (kind == KIND_JUMP || a_node == b_node) begin
              res   <= a_node;
              state <= S_DONE;
            end else begin
              lvl   <= LVL_W'(LEVELS - 1);
              state <= S_D_RA;
            end
          end else if (rem[0]) begin
            state <= S_C_WAIT;
          end else begin
            rem <= rem >> 1;
            lvl <= lvl + LVL_W'(1);
          end
        end
        S_C_WAIT: begin
          a_node <= jt_rdata;
          rem    <= rem >> 1;
          lvl    <= lvl + LVL_W'(1);
          state  <= S_C_STEP;
        end
        // Descend: read both ancestors per level, top level first
        S_D_RA: state <= S_D_RB;
        S_D_RB: begin
          ca    <= jt_rdata;
          state <= S_D_CMP;
        end
        S_D_CMP: begin
          a_node <= a_next;
          b_node <= b_next;
          lvl    <= lvl_dn;
          state  <= (lvl == '0) ? S_F_WAIT : S_D_RB;
        end
        S_F_WAIT: begin
          res   <= jt_rdata;
          state <= S_DONE;
        end
        // Hand the result to the output register once it is free
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_node  <= res;
            out_kind  <= kind;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/binary_lifting_lca.sv =====
// A jump climbs through the jump table one set step bit at a time; a query first lifts the
// deeper node by the depth difference, then descends the levels when the lifted node differs
// from the other.
// A build fills the upper levels of the jump table, bound by the single jump table port.
// One request at a time; the next is taken while a result waits in the output register.
// Reset clears the sequencer, the output valid and sets node_count to 1024; the memories
// hold no reset value and must be written before they are read.
module binary_lifting_lca
  import blca_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // node[9:0], other_node[19:10], node_depth[29:20], steps[39:30]
  input  logic [1:0]   s_tuser,   // action[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [15:0]  m_tdata,   // result_node[9:0], zero fill[15:10]
  output logic [0:0]   m_tuser,   // result_kind[0]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [10:0]  cfg_data   // node_count[10:0]
);

  item_t              item;
  jt_req_t            jt;
  dp_req_t            dp;
  logic [NODE_W-1:0]  jt_rdata;
  logic [DEPTH_W-1:0] dp_rdata;
  logic [CNT_W-1:0]   node_count;
  logic [NODE_W-1:0]  out_node;
  logic               out_kind;

  // Unpack the request
  assign item.action     = action_t'(s_tuser);
  assign item.node       = s_tdata[9:0];
  assign item.other_node = s_tdata[19:10];
  assign item.node_depth = s_tdata[29:20];
  assign item.steps      = s_tdata[39:30];

  // Node count register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= CNT_W'(MAX_NODES);
    end else if (cfg_valid) begin
      node_count <= cfg_data;
    end
  end

  blca_ram #(.DATA_W(NODE_W), .DEPTH(JT_DEPTH)) u_jump_table (
    .clk   (clk),
    .we    (jt.we),
    .waddr (jt.waddr),
    .wdata (jt.wdata),
    .raddr (jt.raddr),
    .rdata (jt_rdata)
  );

  blca_ram #(.DATA_W(DEPTH_W), .DEPTH(MAX_NODES)) u_depth_store (
    .clk   (clk),
    .we    (dp.we),
    .waddr (dp.waddr),
    .wdata (dp.wdata),
    .raddr (dp.raddr),
    .rdata (dp_rdata)
  );

  blca_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (item),
    .node_count (node_count),
    .jt         (jt),
    .jt_rdata   (jt_rdata),
    .dp         (dp),
    .dp_rdata   (dp_rdata),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_node   (out_node),
    .out_kind   (out_kind)
  );

  // Pack the result
  assign m_tdata = {{(16 - NODE_W){1'b0}}, out_node};
  assign m_tuser = out_kind;

endmodule

// ===== src/blca_checker.sv =====
// Port-level checks of the tree ancestor engine, bound to the top level.
module blca_checker
  import blca_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [39:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [0:0]  m_tuser,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [10:0] cfg_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Drop any result on reset
  a_rst_clear: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Keep the fill bits of the result at zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:10] == 6'd0)
    else $error("result fill bits not zero");

  // Write and build requests raise no result
  a_no_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid &&
    (s_tuser == ACT_WRITE || s_tuser == ACT_BUILD) |=> !m_tvalid)
    else $error("result raised by write or build");

  // A query or jump occupies the block past its accepting cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == ACT_QUERY || s_tuser == ACT_JUMP) |=> !s_tready)
    else $error("request taken during a walk");

endmodule

bind binary_lifting_lca blca_checker u_blca_checker (.*);

// ===== verif/binary_lifting_lca_test.sv =====
// Testbench for the tree ancestor engine: loads trees, builds the jump table, checks answers.
module binary_lifting_lca_test;
  import blca_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 24;
  localparam int HOLD_CYCLES = 1500;
  localparam int ROUNDS      = 10;

  // One expected answer
  typedef struct {
    logic [NODE_W-1:0] node;
    logic              kind;
  } answer_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [39:0]        s_tdata = '0;   // node[9:0], other_node[19:10], node_depth[29:20], steps[39:30]
  logic [1:0]         s_tuser = '0;   // action[1:0]
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [15:0]        m_tdata;        // result_node[9:0], zero fill[15:10]
  logic [0:0]         m_tuser;        // result_kind[0]
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [10:0]        cfg_data = '0;  // node_count[10:0]

  // Shadow copy of the tree state and the node count register
  logic [NODE_W-1:0]  anc [LEVELS][MAX_NODES];
  logic [DEPTH_W-1:0] depth_of [MAX_NODES];
  logic [CNT_W-1:0]   node_count_q = CNT_W'(MAX_NODES);

  item_t              pending_reqs [$];
  answer_t            answers_due [$];
  item_t              next_req;
  logic               req_taken = 1'b0;
  int unsigned        send_gap_pct = 0;
  int unsigned        stall_pct = 0;
  int unsigned        hold_left = 0;
  logic               hold_start = 1'b0;
  int unsigned        errors = 0;

  binary_lifting_lca i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Climb one power-of-two jump per set bit
  function automatic logic [NODE_W-1:0] climb_up(logic [NODE_W-1:0] n,
                                                  logic [LEVELS-1:0] hops);
    for (int lv = 0; lv < LEVELS; lv++) begin
      if (hops[lv]) n = anc[lv][n];
    end
    return n;
  endfunction

  // Align depths, then descend the levels while the ancestors differ
  function automatic logic [NODE_W-1:0] common_ancestor(logic [NODE_W-1:0] a,
                                                         logic [NODE_W-1:0] b);
    logic [NODE_W-1:0] t;
    if (depth_of[a] < depth_of[b]) begin
      t = a;
      a = b;
      b = t;
    end
    a = climb_up(a, LEVELS'(depth_of[a] - depth_of[b]));
    if (a == b) return a;
    for (int lv = LEVELS - 1; lv >= 0; lv--) begin
      if (anc[lv][a] != anc[lv][b]) begin
        t = anc[lv][a];
        b = anc[lv][b];
        a = t;
      end
    end
    return anc[0][a];
  endfunction

  // Offer the next request when the bus is free, leaving random gaps
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_taken) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        next_req = pending_reqs.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {next_req.steps, next_req.node_depth, next_req.other_node, next_req.node};
        s_tuser  <= next_req.action;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Count down a long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Stall the result side at random, and fully during a hold-off
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  // Track accepted requests and register writes, check accepted answers
  always @(posedge clk) begin : monitor
    logic [NODE_W-1:0] a, b;
    int                span;
    answer_t           want;
    answer_t           due;
    req_taken <= s_tvalid && s_tready;
    if (rst) begin
      node_count_q = CNT_W'(MAX_NODES);
    end else begin
      if (cfg_valid && cfg_ready) node_count_q = cfg_data;
      if (s_tvalid && s_tready) begin
        a = s_tdata[9:0];
        b = s_tdata[19:10];
        case (action_t'(s_tuser))
          ACT_WRITE: begin
            anc[0][a]   = b;
            depth_of[a] = s_tdata[29:20];
          end
          ACT_BUILD: begin
            span = (node_count_q > MAX_NODES) ? MAX_NODES : node_count_q;
            for (int lv = 1; lv < LEVELS; lv++) begin
              for (int j = 0; j < span; j++) anc[lv][j] = anc[lv-1][anc[lv-1][j]];
            end
          end
          ACT_QUERY: begin
            due = '{common_ancestor(a, b), KIND_LCA};
            answers_due = {answers_due, due};
          end
          ACT_JUMP: begin
            due = '{climb_up(a, LEVELS'(s_tdata[39:30])), KIND_JUMP};
            answers_due = {answers_due, due};
          end
          default: begin
          end
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (answers_due.size() == 0) begin
          $error("result_node: expected none, got %0d", m_tdata[NODE_W-1:0]);
          errors++;
        end else begin
          want = answers_due.pop_front();
          if (m_tdata[NODE_W-1:0] !== want.node) begin
            $error("result_node: expected %0d, got %0d", want.node, m_tdata[NODE_W-1:0]);
            errors++;
          end
          if (m_tuser[0] !== want.kind) begin
            $error("result_kind: expected %0d, got %0d", want.kind, m_tuser[0]);
            errors++;
          end
        end
      end
    end
  end

  // End the run if it hangs
  initial begin : watchdog
    int unsigned ticks;
    ticks = 0;
    while (ticks < CYCLE_LIMIT) begin
      @(posedge clk);
      ticks++;
    end
    $display("[binary_lifting_lca] ERROR");
    $finish;
  end

  task automatic push_req(action_t act, int n, int o, int d, int s);
    item_t r;
    r.action     = act;
    r.node       = FIELD_W'(n);
    r.other_node = FIELD_W'(o);
    r.node_depth = DEPTH_W'(d);
    r.steps      = STEP_W'(s);
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic push_query(int a, int b);
    push_req(ACT_QUERY, a, b, $urandom_range(1023), $urandom_range(1023));
  endtask

  task automatic push_jump(int n, int s);
    push_req(ACT_JUMP, n, $urandom_range(1023), $urandom_range(1023), s);
  endtask

  // Hold until every request is out and every answer is in
  task automatic wait_idle(int extra);
    while (pending_reqs.size() != 0 || s_tvalid || answers_due.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_config(int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= CNT_W'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Load a random tree over distinct labels below span, build, then ask about it among rewrites and rebuilds
  task automatic tree_round(int span, int n_tree, int n_ops, bit allow_rebuild);
    int labels [$];
    int lvl [$];
    bit taken [MAX_NODES];
    int x, i, j, roll;
    while (labels.size() < n_tree) begin
      x = $urandom_range(span - 1);
      if (!taken[x]) begin
        taken[x] = 1'b1;
        labels = {labels, x};
      end
    end
    // root points at itself
    push_req(ACT_WRITE, labels[0], labels[0], 0, $urandom_range(1023));
    lvl = {lvl, 0};
    for (i = 1; i < n_tree; i++) begin
      j = ($urandom_range(99) < 35) ? i - 1 : $urandom_range(i - 1);
      lvl = {lvl, lvl[j] + 1};
      push_req(ACT_WRITE, labels[i], labels[j], lvl[i], $urandom_range(1023));
    end
    push_req(ACT_BUILD, $urandom_range(1023), $urandom_range(1023),
             $urandom_range(1023), $urandom_range(1023));
    for (i = 0; i < n_ops; i++) begin
      roll = $urandom_range(99);
      j    = $urandom_range(n_tree - 1);
      if (roll < 6) begin
        // scramble one node so the loaded tree no longer agrees with itself
        push_req(ACT_WRITE, ($urandom_range(1) == 1) ? labels[j] : $urandom_range(1023),
                 $urandom_range(1023), $urandom_range(1023), $urandom_range(1023));
      end else if (roll < 9 && allow_rebuild) begin
        push_req(ACT_BUILD, $urandom_range(1023), $urandom_range(1023),
                 $urandom_range(1023), $urandom_range(1023));
      end else if (roll < 55) begin
        x = ($urandom_range(9) == 0) ? $urandom_range(1023)
                                      : labels[$urandom_range(n_tree - 1)];
        push_query(($urandom_range(9) == 0) ? $urandom_range(1023) : labels[j], x);
      end else begin
        push_jump(labels[j], ($urandom_range(9) < 7) ? $urandom_range(lvl[j] + 2)
                                                      : $urandom_range(1023));
      end
    end
    // close with an answer so the round is known to be finished
    push_jump(labels[$urandom_range(n_tree - 1)], $urandom_range(1023));
  endtask

  initial begin : stimulus
    int counts [ROUNDS];
    int r, eff, span, n_tree;
    counts = '{1, 48, 0, 96, 2047, 32, 128, 16, 80, 1024};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Full chain over every node: node i hangs below i-1 at depth i
    write_config(MAX_NODES);
    @(posedge clk);
    for (int i = 0; i < MAX_NODES; i++) begin
      push_req(ACT_WRITE, i, (i == 0) ? 0 : i - 1, i, $urandom_range(1023));
    end
    push_req(ACT_BUILD, 0, 0, 0, 0);

    // Deepest jumps, zero steps, climbing past the root
    push_jump(1023, 1023);
    push_jump(1023, 0);
    push_jump(0, 1023);
    push_jump(700, 1023);
    push_jump(1023, 512);
    push_jump(1023, 341);
    // Queries on the chain, including a node with itself
    push_query(1023, 0);
    push_query(0, 1023);
    push_query(345, 345);
    push_query(1023, 512);
    push_query(1, 2);
    // Branch off node 500 and rebuild so the descent has to split
    push_req(ACT_WRITE, 1000, 500, 501, 0);
    push_req(ACT_WRITE, 1001, 1000, 502, 1023);
    push_req(ACT_WRITE, 1002, 500, 501, 0);
    push_req(ACT_WRITE, 1003, 1002, 502, 1023);
    push_req(ACT_BUILD, 1023, 1023, 1023, 1023);
    push_query(1001, 1003);
    push_query(1003, 999);
    push_jump(1001, 2);
    push_query(1000, 1000);
    // Rewrite a parent without rebuilding, leaving stale upper levels
    push_req(ACT_WRITE, 20, 7, 3, 0);
    push_query(20, 30);
    wait_idle(SETTLE);

    // Random trees over several node counts and idling mixes
    for (r = 0; r < ROUNDS; r++) begin
      write_config(counts[r]);
      @(posedge clk);
      case (r % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 46; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 46; end
        default: begin send_gap_pct = 22; stall_pct = 22; end
      endcase
      eff    = (counts[r] > MAX_NODES) ? MAX_NODES : counts[r];
      span   = (eff < 16) ? 64 : eff;
      n_tree = $urandom_range(4, 7);
      tree_round(span, n_tree, 5, eff <= 128);
      if (r == 5) begin
        // queue extra answers, then block the results long enough that the input backs up
        for (int k = 0; k < 4; k++) begin
          push_jump($urandom_range(1023), $urandom_range(1023));
        end
        @(negedge clk);
        hold_start <= 1'b1;
        @(negedge clk);
        hold_start <= 1'b0;
      end
      wait_idle(SETTLE);
    end

    wait_idle(SETTLE * 4);
    if (errors == 0) begin
      $display("[binary_lifting_lca] OK");
    end else begin
      $display("[binary_lifting_lca] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/blca_pkg.sv
src/blca_ram.sv
src/blca_engine.sv
src/binary_lifting_lca.sv
src/blca_checker.sv
verif/binary_lifting_lca_test.sv
